// ===== rtl/core/utf8s_pkg.sv =====
// Shared types, constants and byte classification functions for the UTF-8 splitter.
package utf8s_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned HELD_W   = 40;
   localparam int unsigned CHAR_W   = 48;
   localparam int unsigned LEN_W    = 3;

   localparam logic [7:0] ASCII_TOP    = 8'h80;
   localparam logic [7:0] LEAD2_LOW    = 8'hc2;
   localparam logic [7:0] LEAD3_LOW    = 8'he0;
   localparam logic [7:0] LEAD4_LOW    = 8'hf0;
   localparam logic [7:0] LEAD5_LOW    = 8'hf8;
   localparam logic [7:0] LEAD6_LOW    = 8'hfc;
   localparam logic [7:0] LEAD_TOP     = 8'hfe;
   localparam logic [7:0] CONT_MASK    = 8'hc0;
   localparam logic [7:0] CONT_TAG     = 8'h80;
   localparam logic [7:0] FLOOR_LEAD3  = 8'ha0;
   localparam logic [7:0] FLOOR_LEAD4  = 8'h90;
   localparam logic [7:0] FLOOR_LEAD5  = 8'h88;
   localparam logic [7:0] FLOOR_LEAD6  = 8'h84;
   localparam logic [7:0] FLOOR_PLAIN  = 8'h80;
   localparam logic [LEN_W-1:0] MAX_LEN = 3'd6;

   // Splitter state between bytes of one string.
   typedef struct packed {
      logic [HELD_W-1:0] held_bytes;
      logic [LEN_W-1:0]  expected_length;
      logic [LEN_W-1:0]  bytes_taken;
      logic              halted;
   } state_type;

   // One result item.
   typedef struct packed {
      logic              char_valid;
      logic [CHAR_W-1:0] char_bytes;
      logic [LEN_W-1:0]  char_length;
      logic              stopped;
      logic              string_end;
   } result_type;

   // Character length announced by a lead byte; zero for an illegal lead.
   function automatic logic [LEN_W-1:0] lead_length(input logic [BYTE_W-1:0] b);
      logic [LEN_W-1:0] n;
      priority if (b < ASCII_TOP) n = 3'd1;
      else if (b < LEAD2_LOW)     n = 3'd0;
      else if (b < LEAD3_LOW)     n = 3'd2;
      else if (b < LEAD4_LOW)     n = 3'd3;
      else if (b < LEAD5_LOW)     n = 3'd4;
      else if (b < LEAD6_LOW)     n = 3'd5;
      else if (b < LEAD_TOP)      n = 3'd6;
      else                        n = 3'd0;
      return n;
   endfunction

   // Lowest second byte allowed after a lead, which rules out overlong forms.
   function automatic logic [BYTE_W-1:0] second_floor(input logic [BYTE_W-1:0] lead);
      logic [BYTE_W-1:0] f;
      unique case (lead)
         LEAD3_LOW: f = FLOOR_LEAD3;
         LEAD4_LOW: f = FLOOR_LEAD4;
         LEAD5_LOW: f = FLOOR_LEAD5;
         LEAD6_LOW: f = FLOOR_LEAD6;
         default:   f = FLOOR_PLAIN;
      endcase
      return f;
   endfunction

endpackage

// ===== rtl/core/utf8s_if.sv =====
// Request and response channel interfaces of the UTF-8 splitter.
interface utf8s_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface utf8s_rsp_if;
   logic        valid;
   logic        ready;
   logic        char_valid;
   logic [47:0] char_bytes;
   logic [2:0]  char_length;
   logic        stopped;
   logic        string_end;

   modport source (output valid, output char_valid, output char_bytes, output char_length,
                   output stopped, output string_end, input ready);
   modport sink   (input valid, input char_valid, input char_bytes, input char_length,
                   input stopped, input string_end, output ready);
endinterface

// ===== rtl/core/utf8s_decode.sv =====
// Per-byte decision logic: next splitter state and the result for one byte.
module utf8s_decode (
   input  utf8s_pkg::state_type  state,
   input  logic [7:0]            data_byte,
   input  logic                  last_byte,
   output utf8s_pkg::state_type  state_next,
   output utf8s_pkg::result_type result
);
   import utf8s_pkg::*;

   logic [LEN_W-1:0]  lead_len;
   logic              cont_ok;
   logic              open_bad;
   logic [CHAR_W-1:0] merged;

   assign lead_len = lead_length(data_byte);
   assign cont_ok  = ((data_byte & CONT_MASK) == CONT_TAG) &&
                     !((state.bytes_taken == 3'd1) &&
                       (data_byte < second_floor(state.held_bytes[BYTE_W-1:0])));
   assign open_bad = !cont_ok || (state.bytes_taken == 3'd0) ||
                     (state.bytes_taken >= state.expected_length) ||
                     (state.expected_length > MAX_LEN);
   // The new byte lands above the bytes already held.
   assign merged   = {8'b0, state.held_bytes} |
                     ({40'b0, data_byte} << {state.bytes_taken, 3'b000});

   always_comb begin
      state_next        = state;
      result            = '0;
      result.string_end = last_byte;
      if (!state.halted) begin
         if (state.expected_length == 3'd0) begin
            if (lead_len == 3'd1) begin
               result.char_valid  = 1'b1;
               result.char_bytes  = {40'b0, data_byte};
               result.char_length = 3'd1;
            end else if (lead_len == 3'd0) begin
               state_next.halted = 1'b1;
            end else begin
               state_next.held_bytes      = {32'b0, data_byte};
               state_next.bytes_taken     = 3'd1;
               state_next.expected_length = lead_len;
            end
         end else if (open_bad) begin
            state_next = '0;
            state_next.halted = 1'b1;
         end else if (state.bytes_taken + 3'd1 == state.expected_length) begin
            result.char_valid  = 1'b1;
            result.char_bytes  = merged;
            result.char_length = state.expected_length;
            state_next         = '0;
         end else begin
            state_next.held_bytes  = merged[HELD_W-1:0];
            state_next.bytes_taken = state.bytes_taken + 3'd1;
         end
         // A string that ends inside a character stops on its final byte.
         if (!state_next.halted && last_byte && (state_next.expected_length != 3'd0)) begin
            state_next.halted = 1'b1;
         end
      end
      result.stopped = state_next.halted;
      if (last_byte) begin
         state_next = '0;
      end
   end

endmodule

// ===== rtl/core/utf8_character_splitter.sv =====
// Top level of the UTF-8 character splitter with its output register.
//
// The request channel carries one byte of a string per request, with
// last_byte set on the final byte. Every request gives exactly one response:
// char_valid with the completed character (first byte in bits 7:0) and its
// length, or no character while one is still being gathered. Once a bad byte
// or a string ending inside a character is seen, stopped stays high for the
// rest of that string; string_end echoes last_byte and clears all state.
//
// The response register is loaded in the same cycle the request is taken. One
// request is taken every cycle unless the receiver stalls: the decision is a few
// compares against the held lead byte, done between the splitter state and the
// response register. Requests stay open while a response waits, as long as that
// response is taken in the same cycle. When the receiver stalls, the response
// register holds and req_ch.ready drops. Synchronous reset clears the splitter
// state and empties the response register; no response is pending after reset.
module utf8_character_splitter (
   input  logic          clock,
   input  logic          reset,
   utf8s_req_if.sink     req_ch,
   utf8s_rsp_if.source   rsp_ch
);
   import utf8s_pkg::*;

   state_type  state_ff;
   state_type  state_in;
   result_type result_in;
   result_type result_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       req_take;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_take     = req_ch.valid && req_ch.ready;

   utf8s_decode u_decode (
      .state      (state_ff),
      .data_byte  (req_ch.data_byte),
      .last_byte  (req_ch.last_byte),
      .state_next (state_in),
      .result     (result_in)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_take) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         result_ff <= result_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.char_valid  = result_ff.char_valid;
   assign rsp_ch.char_bytes  = result_ff.char_bytes;
   assign rsp_ch.char_length = result_ff.char_length;
   assign rsp_ch.stopped     = result_ff.stopped;
   assign rsp_ch.string_end  = result_ff.string_end;

`ifndef NO_ASSERTIONS
   // An open character always has at least its lead byte and is not yet full.
   a_open_char: assert property (@(posedge clock) disable iff (reset)
      (state_ff.expected_length != 3'd0) |->
         ((state_ff.bytes_taken != 3'd0) &&
          (state_ff.bytes_taken < state_ff.expected_length) && !state_ff.halted))
      else $error("open character bookkeeping out of range");

   // The final byte of a string leaves the splitter clean for the next string.
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_ch.last_byte) |=> (state_ff == '0))
      else $error("state not cleared after end of string");

   // A completed character has a length and never comes with stopped.
   a_char_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ch.char_valid) |->
         ((rsp_ch.char_length != 3'd0) && !rsp_ch.stopped))
      else $error("completed character with bad length or stop flag");

   // Without a character the response carries no bytes and no length.
   a_no_char_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.char_valid) |->
         ((rsp_ch.char_bytes == '0) && (rsp_ch.char_length == 3'd0)))
      else $error("character bytes present without a character");
`endif

endmodule
